// ----- hdl/bqe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Billboard quad expander package
// Shared widths, latencies and codes of the quad expander pipeline.
// ----------------------------------------------------------------------------
package bqe_pkg;

   // Defaults of the top-level parameters.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int COORD_FRAC_DEF  = 8;

   // Fixed field widths.
   localparam int COLOR_W = 8;
   localparam int SIZE_W  = 16;

   // Normalizer: magnitudes sit in a 64-bit word, one shift stage per bit of
   // the shift count.
   localparam int NORM_W   = 64;
   localparam int NORM_LAT = 6;
   localparam int UNIT_W   = 30;

   // Square root: one result bit per stage over a 64-bit radicand.
   localparam int RAD_W    = 64;
   localparam int ROOT_W   = 31;
   localparam int SQRT_LAT = 32;

   // Divider: one setup stage and one quotient bit per stage.
   localparam int QUOT_W  = 31;
   localparam int DIV_IT  = 31;
   localparam int DIV_LAT = DIV_IT + 1;

   // Fraction bits of the unit vectors.
   localparam int Q_FRAC = 30;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEWER_X = 2'd0,
      CSR_VIEWER_Y = 2'd1,
      CSR_VIEWER_Z = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CORNER_UL = 2'd0,
      CORNER_UR = 2'd1,
      CORNER_LR = 2'd2,
      CORNER_LL = 2'd3
   } corner_type;

   // Per-star flags that ride alongside the arithmetic.
   typedef struct packed {
      logic flat;
      logic neg_x;
      logic neg_y;
      logic neg_z;
   } dflag_type;

endpackage

// ----- hdl/bqe_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Billboard quad expander delay line
// Shift line that moves with the pipeline advance enable.
// ----------------------------------------------------------------------------
module bqe_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

// ----- hdl/bqe_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Billboard quad expander normalizer
// Shifts a group of magnitudes jointly so the largest lands in [2^29, 2^30).
// ----------------------------------------------------------------------------
module bqe_norm #(
   parameter int IN_W  = 33,
   parameter int LANES = 2
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [LANES-1:0][IN_W-1:0]             mag,
   output logic [LANES-1:0][bqe_pkg::UNIT_W-1:0]  unit
);

   localparam int W = bqe_pkg::NORM_W;

   logic [LANES-1:0][W-1:0] lane_in;
   logic [LANES-1:0][W-1:0] stg_ff [bqe_pkg::NORM_LAT];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_in[l] = W'(mag[l]);
      end
   end

   // The top bits of the largest lane are zero exactly when they are zero in
   // the OR of all lanes, so no compare is needed.
   for (genvar j = 0; j < bqe_pkg::NORM_LAT; j++) begin : g_stage
      localparam int SHIFT = W >> (j + 1);
      logic [LANES-1:0][W-1:0] src;
      logic [W-1:0]            any;
      logic                    top_zero;

      if (j == 0) begin : g_first
         assign src = lane_in;
      end else begin : g_next
         assign src = stg_ff[j-1];
      end

      always_comb begin
         any = '0;
         for (int l = 0; l < LANES; l++) begin
            any = any | src[l];
         end
         top_zero = ~|any[W-1 -: SHIFT];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < LANES; l++) begin
               stg_ff[j][l] <= top_zero ? (src[l] << SHIFT) : src[l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         unit[l] = stg_ff[bqe_pkg::NORM_LAT-1][l][W-1 -: bqe_pkg::UNIT_W];
      end
   end

endmodule

// ----- hdl/bqe_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Billboard quad expander square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bqe_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [bqe_pkg::RAD_W-1:0]    rad,
   output logic [bqe_pkg::ROOT_W-1:0]   root
);

   localparam int W   = bqe_pkg::RAD_W;
   localparam int LAT = bqe_pkg::SQRT_LAT;

   logic [W-1:0] res_ff [LAT];
   logic [W-1:0] x_ff   [LAT-1];

   for (genvar j = 0; j < LAT; j++) begin : g_stage
      localparam logic [W-1:0] BIT = W'(1) << (2 * (LAT - 1 - j));
      logic [W-1:0] x_src;
      logic [W-1:0] r_src;
      logic [W-1:0] trial;
      logic         ge;

      if (j == 0) begin : g_first
         assign x_src = rad;
         assign r_src = '0;
      end else begin : g_next
         assign x_src = x_ff[j-1];
         assign r_src = res_ff[j-1];
      end

      assign trial = r_src + BIT;
      assign ge    = x_src >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[j] <= ge ? ((r_src >> 1) + BIT) : (r_src >> 1);
         end
      end

      if (j < LAT - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[j] <= ge ? (x_src - trial) : x_src;
            end
         end
      end
   end

   assign root = res_ff[LAT-1][bqe_pkg::ROOT_W-1:0];

endmodule

// ----- hdl/bqe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Billboard quad expander divider
// Pipelined restoring divider giving round(num * 2^30 / den), num <= den.
// ----------------------------------------------------------------------------
module bqe_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [bqe_pkg::QUOT_W-1:0]  num,
   input  logic [bqe_pkg::QUOT_W-1:0]  den,
   output logic [bqe_pkg::QUOT_W-1:0]  quo
);

   localparam int QW  = bqe_pkg::QUOT_W;
   localparam int IT  = bqe_pkg::DIV_IT;
   localparam int NW  = QW + bqe_pkg::Q_FRAC;

   logic [NW-1:0] dividend;
   logic [QW-1:0] set_rem_ff;
   logic [QW-1:0] set_low_ff;
   logic [QW-1:0] set_den_ff;

   logic [QW-1:0] q_ff   [IT];
   logic [QW-1:0] rem_ff [IT-1];
   logic [QW-1:0] low_ff [IT-1];
   logic [QW-1:0] den_ff [IT-1];

   // Adding half the divisor before dividing rounds half up.
   assign dividend = {num, bqe_pkg::Q_FRAC'(0)} + NW'(den >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         set_rem_ff <= QW'(dividend[NW-1:QW]);
         set_low_ff <= dividend[QW-1:0];
         set_den_ff <= den;
      end
   end

   for (genvar j = 0; j < IT; j++) begin : g_stage
      logic [QW-1:0] rem_src;
      logic [QW-1:0] low_src;
      logic [QW-1:0] den_src;
      logic [QW-1:0] q_src;
      logic [QW:0]   rem2;
      logic [QW:0]   diff;
      logic          ge;

      if (j == 0) begin : g_first
         assign rem_src = set_rem_ff;
         assign low_src = set_low_ff;
         assign den_src = set_den_ff;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign low_src = low_ff[j-1];
         assign den_src = den_ff[j-1];
         assign q_src   = q_ff[j-1];
      end

      assign rem2 = {rem_src, low_src[QW-1-j]};
      assign diff = rem2 - {1'b0, den_src};
      assign ge   = rem2 >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j] <= {q_src[QW-2:0], ge};
         end
      end

      if (j < IT - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge ? diff[QW-1:0] : rem2[QW-1:0];
               low_ff[j] <= low_src;
               den_ff[j] <= den_src;
            end
         end
      end
   end

   assign quo = q_ff[IT-1];

endmodule

// ----- hdl/billboard_quad_expander_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Billboard quad expander core
// Expands one star sprite into four viewer-facing quad corner vertices.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Content
//  --------+-----------+----------------------+--------------------------------
//  req     | in        | req_tvalid/tready    | one star per beat, tlast = end
//          |           |                      | of frame
//  rsp     | out       | rsp_tvalid/tready    | one corner per beat, UL UR LR LL,
//          |           |                      | tlast on the lower left corner
//  csr     | in        | csr_valid/csr_ready  | viewer position writes
//
// Each star gives four result beats, and the single output serializer
// sets the throughput: it takes the next star as its last corner beat is
// accepted. A star goes through the normalizers, the square root and
// divider pipelines and the scale stages before its first corner beat.
// Reset is synchronous and clears the valid bits, the serializer and the
// viewer registers; no memory needs a clearing pass. When the serializer
// cannot take the next star, the whole pipeline holds at once, so nothing
// is lost or repeated, and request beats are taken whenever it advances.
//
// The offset d = viewer - star is kept as sign and magnitude. Its horizontal
// pair and its full triple are normalized, the lengths come from pipelined
// square roots, and pipelined dividers give the unit right (-ey, ex, 0) and
// unit up (-v*ex, -v*ey, h) vectors in Q30. Both are scaled by the size with
// rounding half away from zero, then the serializer adds them to the centre
// with saturation, one corner per beat.
// ----------------------------------------------------------------------------
module billboard_quad_expander_core #(
   parameter int COORD_WIDTH = bqe_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC  = bqe_pkg::COORD_FRAC_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // star_x, star_y, star_z, red_in, green_in, blue_in, alpha_in, sprite_size
   input  logic [((3*COORD_WIDTH+48+7)/8)*8-1:0]  req_tdata,
   input  logic                                   req_tlast,    // end_of_frame

   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // vert_x, vert_y, vert_z, red_out, green_out, blue_out, alpha_out
   output logic [((3*COORD_WIDTH+32+7)/8)*8-1:0]  rsp_tdata,
   // tex_u, tex_v, frame_done
   output logic [2:0]                             rsp_tuser,
   output logic                                   rsp_tlast,    // last_corner

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bqe_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_data
);

   localparam int CW      = COORD_WIDTH;
   localparam int DW      = CW + 1;
   localparam int SH      = 38 - COORD_FRAC;
   localparam int QW      = bqe_pkg::QUOT_W;
   localparam int UW      = bqe_pkg::UNIT_W;
   localparam int ZW      = bqe_pkg::SIZE_W;
   localparam int CLW     = bqe_pkg::COLOR_W;
   localparam int PR_W    = QW + ZW;
   localparam int PW_W    = 2 * QW;
   localparam int MAG_W   = PR_W - SH;
   localparam int OFS_W   = MAG_W + 1;
   localparam int SUM_W   = ((CW > OFS_W) ? CW : OFS_W) + 2;
   localparam int SQ_W    = 2 * UW;
   localparam int RW      = bqe_pkg::RAD_W;
   localparam int FW      = $bits(bqe_pkg::dflag_type);
   localparam int COL_OFS = 3 * CW;
   localparam int SIZ_OFS = 3 * CW + 4 * CLW;
   localparam int SIDE_W  = 3 * CW + 4 * CLW + 1;

   // Pipeline positions of the registered results.
   localparam int LAT_NORM = 1 + bqe_pkg::NORM_LAT;
   localparam int LAT_SQRT = LAT_NORM + 2 + bqe_pkg::SQRT_LAT;
   localparam int LAT_DIV  = LAT_SQRT + bqe_pkg::DIV_LAT;
   localparam int LAT_END  = LAT_DIV + 4;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((65'sd1 <<< (CW - 1)) - 65'sd1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   // ------------------------------------------------------------------------
   // Viewer registers.
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] viewer_x_ff;
   logic signed [CW-1:0] viewer_y_ff;
   logic signed [CW-1:0] viewer_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
         viewer_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            bqe_pkg::CSR_VIEWER_X: viewer_x_ff <= csr_data;
            bqe_pkg::CSR_VIEWER_Y: viewer_y_ff <= csr_data;
            bqe_pkg::CSR_VIEWER_Z: viewer_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Advance control. Every stage moves together; valid bits run beside.
   // ------------------------------------------------------------------------
   logic                 adv;
   logic                 load;
   logic [LAT_END-1:0]   vld_ff;
   logic                 vld_end;

   assign vld_end    = vld_ff[LAT_END-1];
   assign adv        = !vld_end || load;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT_END-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: offset from the star to the viewer, in sign and magnitude.
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] star_x;
   logic signed [CW-1:0] star_y;
   logic signed [CW-1:0] star_z;
   logic [ZW-1:0]        size_in;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [DW-1:0] dz;

   assign star_x  = req_tdata[CW-1:0];
   assign star_y  = req_tdata[2*CW-1:CW];
   assign star_z  = req_tdata[3*CW-1:2*CW];
   assign size_in = req_tdata[SIZ_OFS +: ZW];

   assign dx = {viewer_x_ff[CW-1], viewer_x_ff} - {star_x[CW-1], star_x};
   assign dy = {viewer_y_ff[CW-1], viewer_y_ff} - {star_y[CW-1], star_y};
   assign dz = {viewer_z_ff[CW-1], viewer_z_ff} - {star_z[CW-1], star_z};

   logic [DW-1:0]      mag_x_ff;
   logic [DW-1:0]      mag_y_ff;
   logic [DW-1:0]      mag_z_ff;
   bqe_pkg::dflag_type flag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_x_ff      <= dx[DW-1] ? DW'(-dx) : DW'(dx);
         mag_y_ff      <= dy[DW-1] ? DW'(-dy) : DW'(dy);
         mag_z_ff      <= dz[DW-1] ? DW'(-dz) : DW'(dz);
         flag_ff.flat  <= (dx == '0) && (dy == '0);
         flag_ff.neg_x <= dx[DW-1];
         flag_ff.neg_y <= dy[DW-1];
         flag_ff.neg_z <= dz[DW-1];
      end
   end

   // ------------------------------------------------------------------------
   // Normalize the horizontal pair and the full triple.
   // ------------------------------------------------------------------------
   logic [1:0][UW-1:0] pair_unit;
   logic [2:0][UW-1:0] trip_unit;

   bqe_norm #(.IN_W(DW), .LANES(2)) u_norm_pair (
      .clock (clock),
      .en    (adv),
      .mag   ({mag_y_ff, mag_x_ff}),
      .unit  (pair_unit)
   );

   bqe_norm #(.IN_W(DW), .LANES(3)) u_norm_trip (
      .clock (clock),
      .en    (adv),
      .mag   ({mag_z_ff, mag_y_ff, mag_x_ff}),
      .unit  (trip_unit)
   );

   // ------------------------------------------------------------------------
   // Squares, then the sums that feed the square roots.
   // ------------------------------------------------------------------------
   logic [SQ_W-1:0] sq_a_ff;
   logic [SQ_W-1:0] sq_b_ff;
   logic [SQ_W-1:0] sq_ta_ff;
   logic [SQ_W-1:0] sq_tb_ff;
   logic [SQ_W-1:0] sq_tc_ff;
   logic [RW-1:0]   sum_h_ff;
   logic [RW-1:0]   sum_r_ff;
   logic [RW-1:0]   sum_l_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_a_ff  <= SQ_W'(pair_unit[0]) * SQ_W'(pair_unit[0]);
         sq_b_ff  <= SQ_W'(pair_unit[1]) * SQ_W'(pair_unit[1]);
         sq_ta_ff <= SQ_W'(trip_unit[0]) * SQ_W'(trip_unit[0]);
         sq_tb_ff <= SQ_W'(trip_unit[1]) * SQ_W'(trip_unit[1]);
         sq_tc_ff <= SQ_W'(trip_unit[2]) * SQ_W'(trip_unit[2]);
         sum_h_ff <= RW'(sq_a_ff) + RW'(sq_b_ff);
         sum_r_ff <= RW'(sq_ta_ff) + RW'(sq_tb_ff);
         sum_l_ff <= RW'(sq_ta_ff) + RW'(sq_tb_ff) + RW'(sq_tc_ff);
      end
   end

   logic [bqe_pkg::ROOT_W-1:0] root_h;
   logic [bqe_pkg::ROOT_W-1:0] root_r;
   logic [bqe_pkg::ROOT_W-1:0] root_l;

   bqe_sqrt u_sqrt_h (.clock(clock), .en(adv), .rad(sum_h_ff), .root(root_h));
   bqe_sqrt u_sqrt_r (.clock(clock), .en(adv), .rad(sum_r_ff), .root(root_r));
   bqe_sqrt u_sqrt_l (.clock(clock), .en(adv), .rad(sum_l_ff), .root(root_l));

   // The numerators wait beside the squares and the square roots.
   logic [3*UW-1:0] numer_dly;

   bqe_delay #(.WIDTH(3 * UW), .DEPTH(LAT_SQRT - LAT_NORM)) u_numer_dly (
      .clock (clock),
      .en    (adv),
      .din   ({trip_unit[2], pair_unit[1], pair_unit[0]}),
      .dout  (numer_dly)
   );

   // ------------------------------------------------------------------------
   // Unit vector components in Q30, as magnitudes.
   // ------------------------------------------------------------------------
   logic [QW-1:0] quo_x;
   logic [QW-1:0] quo_y;
   logic [QW-1:0] quo_h;
   logic [QW-1:0] quo_v;

   bqe_div u_div_x (
      .clock (clock), .en (adv),
      .num   (QW'(numer_dly[UW-1:0])), .den (root_h), .quo (quo_x)
   );

   bqe_div u_div_y (
      .clock (clock), .en (adv),
      .num   (QW'(numer_dly[2*UW-1:UW])), .den (root_h), .quo (quo_y)
   );

   bqe_div u_div_h (
      .clock (clock), .en (adv),
      .num   (root_r), .den (root_l), .quo (quo_h)
   );

   bqe_div u_div_v (
      .clock (clock), .en (adv),
      .num   (QW'(numer_dly[3*UW-1:2*UW])), .den (root_l), .quo (quo_v)
   );

   bqe_pkg::dflag_type flag_dly;
   logic [ZW-1:0]      size_dly;

   bqe_delay #(.WIDTH(FW), .DEPTH(LAT_DIV - 1)) u_flag_dly (
      .clock (clock),
      .en    (adv),
      .din   (flag_ff),
      .dout  (flag_dly)
   );

   bqe_delay #(.WIDTH(ZW), .DEPTH(LAT_DIV)) u_size_dly (
      .clock (clock),
      .en    (adv),
      .din   (size_in),
      .dout  (size_dly)
   );

   // ------------------------------------------------------------------------
   // Scale stages. A star straight above or below the viewer has no
   // horizontal direction, so both axes are forced to zero.
   // ------------------------------------------------------------------------
   logic [QW-1:0] qx_m;
   logic [QW-1:0] qy_m;
   logic [QW-1:0] qh_m;
   logic [QW-1:0] qv_m;

   assign qx_m = flag_dly.flat ? '0 : quo_x;
   assign qy_m = flag_dly.flat ? '0 : quo_y;
   assign qh_m = flag_dly.flat ? '0 : quo_h;
   assign qv_m = flag_dly.flat ? '0 : quo_v;

   logic [PW_W-1:0]    pw0_ff;
   logic [PW_W-1:0]    pw1_ff;
   logic [PR_W-1:0]    pr0_ff;
   logic [PR_W-1:0]    pr1_ff;
   logic [PR_W-1:0]    pu2_ff;
   bqe_pkg::dflag_type flag_a_ff;
   logic [ZW-1:0]      size_a_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pw0_ff    <= PW_W'(qv_m) * PW_W'(qx_m);
         pw1_ff    <= PW_W'(qv_m) * PW_W'(qy_m);
         pr0_ff    <= PR_W'(qy_m) * PR_W'(size_dly);
         pr1_ff    <= PR_W'(qx_m) * PR_W'(size_dly);
         pu2_ff    <= PR_W'(qh_m) * PR_W'(size_dly);
         flag_a_ff <= flag_dly;
         size_a_ff <= size_dly;
      end
   end

   logic [PW_W-1:0] pw0_rnd;
   logic [PW_W-1:0] pw1_rnd;
   logic [PR_W-1:0] pr0_rnd;
   logic [PR_W-1:0] pr1_rnd;
   logic [PR_W-1:0] pu2_rnd;

   assign pw0_rnd = pw0_ff + (PW_W'(1) << (bqe_pkg::Q_FRAC - 1));
   assign pw1_rnd = pw1_ff + (PW_W'(1) << (bqe_pkg::Q_FRAC - 1));
   assign pr0_rnd = pr0_ff + (PR_W'(1) << (SH - 1));
   assign pr1_rnd = pr1_ff + (PR_W'(1) << (SH - 1));
   assign pu2_rnd = pu2_ff + (PR_W'(1) << (SH - 1));

   logic [QW-1:0]             w0_ff;
   logic [QW-1:0]             w1_ff;
   logic signed [OFS_W-1:0]   r0_b_ff;
   logic signed [OFS_W-1:0]   r1_b_ff;
   logic signed [OFS_W-1:0]   u2_b_ff;
   bqe_pkg::dflag_type        flag_b_ff;
   logic [ZW-1:0]             size_b_ff;
   logic [MAG_W-1:0]          r0_mag;
   logic [MAG_W-1:0]          r1_mag;
   logic [MAG_W-1:0]          u2_mag;

   assign r0_mag = MAG_W'(pr0_rnd >> SH);
   assign r1_mag = MAG_W'(pr1_rnd >> SH);
   assign u2_mag = MAG_W'(pu2_rnd >> SH);

   // Right x is -ey*size, so its sign is the opposite of dy.
   always_ff @(posedge clock) begin
      if (adv) begin
         w0_ff     <= QW'(pw0_rnd >> bqe_pkg::Q_FRAC);
         w1_ff     <= QW'(pw1_rnd >> bqe_pkg::Q_FRAC);
         r0_b_ff   <= flag_a_ff.neg_y ? OFS_W'(r0_mag) : -OFS_W'(r0_mag);
         r1_b_ff   <= flag_a_ff.neg_x ? -OFS_W'(r1_mag) : OFS_W'(r1_mag);
         u2_b_ff   <= OFS_W'(u2_mag);
         flag_b_ff <= flag_a_ff;
         size_b_ff <= size_a_ff;
      end
   end

   logic [PR_W-1:0]         pu0_ff;
   logic [PR_W-1:0]         pu1_ff;
   logic signed [OFS_W-1:0] r0_c_ff;
   logic signed [OFS_W-1:0] r1_c_ff;
   logic signed [OFS_W-1:0] u2_c_ff;
   bqe_pkg::dflag_type      flag_c_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pu0_ff    <= PR_W'(w0_ff) * PR_W'(size_b_ff);
         pu1_ff    <= PR_W'(w1_ff) * PR_W'(size_b_ff);
         r0_c_ff   <= r0_b_ff;
         r1_c_ff   <= r1_b_ff;
         u2_c_ff   <= u2_b_ff;
         flag_c_ff <= flag_b_ff;
      end
   end

   logic [PR_W-1:0]         pu0_rnd;
   logic [PR_W-1:0]         pu1_rnd;
   logic [MAG_W-1:0]        u0_mag;
   logic [MAG_W-1:0]        u1_mag;
   logic signed [OFS_W-1:0] u0_d_ff;
   logic signed [OFS_W-1:0] u1_d_ff;
   logic signed [OFS_W-1:0] u2_d_ff;
   logic signed [OFS_W-1:0] r0_d_ff;
   logic signed [OFS_W-1:0] r1_d_ff;

   assign pu0_rnd = pu0_ff + (PR_W'(1) << (SH - 1));
   assign pu1_rnd = pu1_ff + (PR_W'(1) << (SH - 1));
   assign u0_mag  = MAG_W'(pu0_rnd >> SH);
   assign u1_mag  = MAG_W'(pu1_rnd >> SH);

   // Up x and y are -(v*e)*size: negative when v and e share a sign.
   always_ff @(posedge clock) begin
      if (adv) begin
         u0_d_ff <= (flag_c_ff.neg_z ^ flag_c_ff.neg_x) ? OFS_W'(u0_mag) : -OFS_W'(u0_mag);
         u1_d_ff <= (flag_c_ff.neg_z ^ flag_c_ff.neg_y) ? OFS_W'(u1_mag) : -OFS_W'(u1_mag);
         u2_d_ff <= u2_c_ff;
         r0_d_ff <= r0_c_ff;
         r1_d_ff <= r1_c_ff;
      end
   end

   // Centre, colour and frame mark travel beside the whole pipeline.
   logic [SIDE_W-1:0] side_dly;

   bqe_delay #(.WIDTH(SIDE_W), .DEPTH(LAT_END)) u_side_dly (
      .clock (clock),
      .en    (adv),
      .din   ({req_tlast, req_tdata[SIZ_OFS-1:0]}),
      .dout  (side_dly)
   );

   // ------------------------------------------------------------------------
   // Output serializer: holds one star and sends its four corners.
   // ------------------------------------------------------------------------
   logic                    ser_busy_ff;
   logic                    ser_busy_in;
   bqe_pkg::corner_type     ser_k_ff;
   bqe_pkg::corner_type     ser_k_in;
   logic signed [CW-1:0]    ser_sx_ff;
   logic signed [CW-1:0]    ser_sy_ff;
   logic signed [CW-1:0]    ser_sz_ff;
   logic signed [OFS_W-1:0] ser_u0_ff;
   logic signed [OFS_W-1:0] ser_u1_ff;
   logic signed [OFS_W-1:0] ser_u2_ff;
   logic signed [OFS_W-1:0] ser_r0_ff;
   logic signed [OFS_W-1:0] ser_r1_ff;
   logic [4*CLW-1:0]        ser_color_ff;
   logic                    ser_eof_ff;
   logic                    beat_done;
   logic                    last_beat;

   assign rsp_tvalid = ser_busy_ff;
   assign beat_done  = ser_busy_ff && rsp_tready;
   assign last_beat  = ser_k_ff == bqe_pkg::CORNER_LL;
   assign load       = vld_end && (!ser_busy_ff || (beat_done && last_beat));

   always_comb begin
      ser_busy_in = ser_busy_ff;
      ser_k_in    = ser_k_ff;
      if (load) begin
         ser_busy_in = 1'b1;
         ser_k_in    = bqe_pkg::CORNER_UL;
      end else if (beat_done) begin
         case (ser_k_ff)
            bqe_pkg::CORNER_UL: ser_k_in = bqe_pkg::CORNER_UR;
            bqe_pkg::CORNER_UR: ser_k_in = bqe_pkg::CORNER_LR;
            bqe_pkg::CORNER_LR: ser_k_in = bqe_pkg::CORNER_LL;
            default:            ser_busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_busy_ff <= 1'b0;
         ser_k_ff    <= bqe_pkg::CORNER_UL;
      end else begin
         ser_busy_ff <= ser_busy_in;
         ser_k_ff    <= ser_k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ser_sx_ff    <= side_dly[CW-1:0];
         ser_sy_ff    <= side_dly[2*CW-1:CW];
         ser_sz_ff    <= side_dly[3*CW-1:2*CW];
         ser_color_ff <= side_dly[COL_OFS +: 4*CLW];
         ser_eof_ff   <= side_dly[SIDE_W-1];
         ser_u0_ff    <= u0_d_ff;
         ser_u1_ff    <= u1_d_ff;
         ser_u2_ff    <= u2_d_ff;
         ser_r0_ff    <= r0_d_ff;
         ser_r1_ff    <= r1_d_ff;
      end
   end

   // Upper corners add the up axis, right corners add the right axis.
   logic                    is_upper;
   logic                    is_right;
   logic signed [SUM_W-1:0] cx;
   logic signed [SUM_W-1:0] cy;
   logic signed [SUM_W-1:0] cz;
   logic signed [SUM_W-1:0] u0_e;
   logic signed [SUM_W-1:0] u1_e;
   logic signed [SUM_W-1:0] u2_e;
   logic signed [SUM_W-1:0] r0_e;
   logic signed [SUM_W-1:0] r1_e;
   logic signed [CW-1:0]    vx;
   logic signed [CW-1:0]    vy;
   logic signed [CW-1:0]    vz;

   assign is_upper = ser_k_ff inside {bqe_pkg::CORNER_UL, bqe_pkg::CORNER_UR};
   assign is_right = ser_k_ff inside {bqe_pkg::CORNER_UR, bqe_pkg::CORNER_LR};

   always_comb begin
      u0_e = is_upper ? SUM_W'(ser_u0_ff) : -SUM_W'(ser_u0_ff);
      u1_e = is_upper ? SUM_W'(ser_u1_ff) : -SUM_W'(ser_u1_ff);
      u2_e = is_upper ? SUM_W'(ser_u2_ff) : -SUM_W'(ser_u2_ff);
      r0_e = is_right ? SUM_W'(ser_r0_ff) : -SUM_W'(ser_r0_ff);
      r1_e = is_right ? SUM_W'(ser_r1_ff) : -SUM_W'(ser_r1_ff);
      cx   = SUM_W'(ser_sx_ff) + u0_e + r0_e;
      cy   = SUM_W'(ser_sy_ff) + u1_e + r1_e;
      cz   = SUM_W'(ser_sz_ff) + u2_e;
      vx   = (cx > SAT_HI) ? CW'(SAT_HI) : ((cx < SAT_LO) ? CW'(SAT_LO) : CW'(cx));
      vy   = (cy > SAT_HI) ? CW'(SAT_HI) : ((cy < SAT_LO) ? CW'(SAT_LO) : CW'(cy));
      vz   = (cz > SAT_HI) ? CW'(SAT_HI) : ((cz < SAT_LO) ? CW'(SAT_LO) : CW'(cz));
   end

   always_comb begin
      rsp_tdata                      = '0;
      rsp_tdata[CW-1:0]              = vx;
      rsp_tdata[2*CW-1:CW]           = vy;
      rsp_tdata[3*CW-1:2*CW]         = vz;
      rsp_tdata[COL_OFS +: 4*CLW]    = ser_color_ff;
      rsp_tuser[0]                   = is_right;
      rsp_tuser[1]                   = !is_upper;
      rsp_tuser[2]                   = last_beat && ser_eof_ff;
      rsp_tlast                      = last_beat;
   end

endmodule
